FILE: rtl/lcpd_pkg.sv
// Package for the LED colour to PWM duty converter.
// Field widths, register codes, divider constants and the CIE x / warm fraction tables.
// No dependencies.
`default_nettype none

package lcpd_pkg;

	localparam int PER_W      = 20;
	localparam int DUTY_W     = 20;
	localparam int RGB_W      = 24;
	localparam int KELVIN_W   = 15;
	localparam int BRIGHT_W   = 10;
	localparam int MASK_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam int TABLE_DEPTH = 381;
	localparam int BRIGHT_FULL = 1000;
	localparam int CHANNELS    = 5;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	localparam int K_LOW     = 2700;
	localparam int K_HIGH    = 6500;
	localparam int K_STEP    = 10;
	localparam int K_TOP     = K_HIGH + K_STEP - 1;
	localparam int KOFF_W    = $clog2(K_TOP - K_LOW + 1);
	localparam int RAMP_STEP = 38;
	localparam int RAMP_MAX  = 100;
	localparam int RAMP_W    = $clog2(RAMP_MAX + 1);
	localparam int LEVEL_MAX = 255;

	localparam int X_COOL    = 3135;
	localparam int X_WARM    = 4593;
	localparam int Y_COOL    = 3237;
	localparam int Y_WARM    = 4107;
	localparam int FRAC_SH   = 16;
	localparam int FRAC_ONE  = 65536;
	localparam int FRAC_W    = FRAC_SH + 1;

	localparam int PER_RST   = 1000;
	localparam int MASK_RST  = 63;

	// polarity mask bits
	localparam int CH_RED    = 0;
	localparam int CH_GREEN  = 1;
	localparam int CH_BLUE   = 2;
	localparam int CH_WARM   = 3;
	localparam int CH_COOL   = 4;
	localparam int CH_BRIGHT = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD     = 2'd0,
		REG_WHITE_MODE = 2'd1,
		REG_POLARITY   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [PER_W-1:0]  period;
		logic              white_mode;
		logic [MASK_W-1:0] active_high;
	} cfg_regs_t;

	typedef logic [12:0] cie_x_t [TABLE_DEPTH];
	typedef logic [FRAC_W-1:0] frac_rom_t [TABLE_DEPTH];

	localparam cie_x_t CIE_X = '{
		4593,4585,4577,4569,4561,4553,4545,4537,4529,4521,
		4514,4506,4498,4490,4483,4475,4468,4460,4453,4445,
		4438,4430,4423,4416,4409,4401,4394,4387,4380,4373,
		4366,4359,4352,4345,4338,4331,4324,4317,4311,4304,
		4297,4290,4284,4277,4271,4264,4258,4251,4245,4238,
		4232,4225,4219,4213,4207,4200,4194,4188,4182,4176,
		4170,4163,4157,4151,4145,4139,4134,4128,4122,4116,
		4110,4104,4099,4093,4087,4081,4076,4070,4065,4059,
		4053,4048,4042,4037,4031,4026,4021,4015,4010,4005,
		3999,3994,3989,3984,3978,3973,3968,3963,3958,3953,
		3948,3942,3937,3932,3927,3923,3918,3913,3908,3903,
		3898,3893,3888,3884,3879,3874,3869,3865,3860,3855,
		3851,3846,3841,3837,3832,3828,3823,3819,3814,3810,
		3805,3800,3796,3791,3787,3783,3778,3774,3770,3766,
		3761,3757,3753,3749,3745,3740,3736,3732,3728,3724,
		3720,3716,3712,3708,3704,3700,3696,3692,3688,3684,
		3681,3677,3673,3669,3665,3662,3658,3654,3650,3647,
		3643,3639,3636,3632,3628,3625,3621,3618,3614,3611,
		3607,3604,3600,3597,3593,3590,3586,3583,3580,3576,
		3673,3569,3566,3563,3559,3556,3553,3550,3546,3543,
		3540,3537,3534,3530,3527,3524,3521,3518,3515,3512,
		3509,3506,3503,3499,3496,3493,3490,3487,3485,3482,
		3479,3476,3473,3470,3467,3464,3461,3458,3456,3453,
		3450,3447,3444,3442,3439,3436,3433,3431,3428,3425,
		3422,3420,3417,3414,3412,3409,3406,3404,3401,3399,
		3396,3394,3391,3388,3386,3383,3381,3378,3376,3373,
		3371,3368,3366,3363,3361,3359,3356,3354,3351,3349,
		3347,3344,3342,3340,3337,3335,3333,3330,3328,3326,
		3326,3321,3319,3317,3314,3312,3310,3308,3305,3303,
		3301,3299,3297,3295,3292,3290,3288,3286,3284,3282,
		3280,3278,3275,3273,3271,3269,3267,3265,3263,3261,
		3259,3257,3255,3253,3251,3249,3247,3245,3243,3241,
		3239,3237,3235,3233,3232,3230,3228,3226,3224,3222,
		3220,3218,3216,3215,3213,3211,3209,3207,3205,3204,
		3202,3200,3198,3196,3195,3193,3191,3189,3188,3186,
		3184,3182,3181,3179,3177,3176,3174,3172,3171,3169,
		3167,3165,3164,3162,3161,3159,3157,3156,3154,3152,
		3151,3149,3148,3146,3144,3143,3141,3140,3138,3136,
		3135
	};

	// Q1.16 warm fraction per table row, evaluated at elaboration by long division
	function automatic frac_rom_t build_frac();
		frac_rom_t         rom;
		logic [39:0]       num;
		logic [24:0]       den;
		logic [25:0]       rem;
		logic [FRAC_W-1:0] q;
		int                x;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			x = int'(CIE_X[i]);
			if (x <= X_COOL) begin
				rom[i] = '0;
			end else if (x >= X_WARM) begin
				rom[i] = FRAC_W'(FRAC_ONE);
			end else begin
				num = 40'(Y_WARM * (x - X_COOL)) << FRAC_SH;
				den = 25'(Y_WARM * (x - X_COOL) + Y_COOL * (X_WARM - x));
				rem = '0;
				q   = '0;
				for (int k = 39; k >= 0; k--) begin
					rem = {rem[24:0], num[k]};
					if (rem >= 26'(den)) begin
						rem = rem - 26'(den);
						if (k < FRAC_W) q[k] = 1'b1;
					end
				end
				rom[i] = q;
			end
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/lcpd_if.sv
// Channel interfaces: request, duty result and register write.
// Depends on lcpd_pkg.
`default_nettype none

interface lcpd_req_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [lcpd_pkg::RGB_W-1:0]     colour_rgb;
	logic [lcpd_pkg::KELVIN_W-1:0]  colour_temp_kelvin;
	logic [lcpd_pkg::BRIGHT_W-1:0]  brightness;
	modport source (output valid, kind, colour_rgb, colour_temp_kelvin, brightness,
		input ready);
	modport sink (input valid, kind, colour_rgb, colour_temp_kelvin, brightness,
		output ready);
endinterface

interface lcpd_duty_if;
	logic                         valid;
	logic                         ready;
	logic [lcpd_pkg::DUTY_W-1:0]  duty_red;
	logic [lcpd_pkg::DUTY_W-1:0]  duty_green;
	logic [lcpd_pkg::DUTY_W-1:0]  duty_blue;
	logic [lcpd_pkg::DUTY_W-1:0]  duty_third_white;
	logic [lcpd_pkg::DUTY_W-1:0]  duty_fourth_white;
	logic                         status;
	modport source (output valid, duty_red, duty_green, duty_blue, duty_third_white,
		duty_fourth_white, status, input ready);
	modport sink (input valid, duty_red, duty_green, duty_blue, duty_third_white,
		duty_fourth_white, status, output ready);
endinterface

interface lcpd_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [lcpd_pkg::CFG_IDX_W-1:0]   index;
	logic [lcpd_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/lcpd_cfg.sv
// Configuration register file: period, white drive mode, channel polarity.
// Depends on lcpd_pkg and lcpd_if.
`default_nettype none

module lcpd_cfg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	lcpd_cfg_if.sink                 cfg,
	output lcpd_pkg::cfg_regs_t      regs
);
	import lcpd_pkg::*;

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.period      <= PER_W'(PER_RST);
			regs_q.white_mode  <= 1'b0;
			regs_q.active_high <= MASK_W'(MASK_RST);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PERIOD:     regs_q.period      <= cfg.data[PER_W-1:0];
				REG_WHITE_MODE: regs_q.white_mode  <= cfg.data[0];
				REG_POLARITY:   regs_q.active_high <= cfg.data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lcpd_rgb_lane.sv
// One colour lane: level * period / 255, then * brightness / 1000, result at stage 8.
// Depends on lcpd_pkg.
`default_nettype none

module lcpd_rgb_lane (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [7:0]                     level,
	input  wire logic [lcpd_pkg::BRIGHT_W-1:0]  bright,
	input  wire logic [lcpd_pkg::PER_W-1:0]     period,
	output logic [lcpd_pkg::DUTY_W-1:0]         duty_s8
);
	import lcpd_pkg::*;

	localparam int P1_W = 8 + PER_W;
	localparam int M1_W = P1_W - 7;
	localparam logic [M1_W-1:0] M1 = M1_W'((64'd1 << P1_W) / LEVEL_MAX);
	localparam int P2_W = DUTY_W + BRIGHT_W;
	localparam int M2_W = P2_W - 9;
	localparam logic [M2_W-1:0] M2 = M2_W'((64'd1 << P2_W) / BRIGHT_FULL);

	logic [P1_W-1:0]      p1_s2, p1_s3;
	logic [BRIGHT_W-1:0]  b_s2, b_s3, b_s4;
	logic [DUTY_W-1:0]    q1_s3, full_s4, q2_s6, q_s7;
	logic [P2_W-1:0]      p2_s5, p2_s6;
	logic [P1_W+M1_W-1:0] prod1;
	logic [P2_W+M2_W-1:0] prod2;
	logic [P1_W-1:0]      r1;
	logic [P2_W-1:0]      r2;

	assign prod1 = (P1_W+M1_W)'(p1_s2) * (P1_W+M1_W)'(M1);
	assign prod2 = (P2_W+M2_W)'(p2_s5) * (P2_W+M2_W)'(M2);
	assign r1    = p1_s3 - P1_W'(q1_s3) * P1_W'(LEVEL_MAX);
	assign r2    = p2_s6 - P2_W'(q2_s6) * P2_W'(BRIGHT_FULL);

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2   <= P1_W'(level) * P1_W'(period);
			b_s2    <= bright;
			q1_s3   <= prod1[P1_W +: DUTY_W];
			p1_s3   <= p1_s2;
			b_s3    <= b_s2;
			full_s4 <= q1_s3 + DUTY_W'(r1 >= P1_W'(LEVEL_MAX));
			b_s4    <= b_s3;
			p2_s5   <= P2_W'(full_s4) * P2_W'(b_s4);
			q2_s6   <= prod2[P2_W +: DUTY_W];
			p2_s6   <= p2_s5;
			q_s7    <= q2_s6 + DUTY_W'(r2 >= P2_W'(BRIGHT_FULL));
			duty_s8 <= q_s7;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/lcpd_white.sv
// White path: table index, warm fraction ROM, warm/cool split, ramp and brightness channels.
// All results at stage 8. Depends on lcpd_pkg.
`default_nettype none

module lcpd_white (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [lcpd_pkg::KELVIN_W-1:0]  kelvin,
	input  wire logic [lcpd_pkg::BRIGHT_W-1:0]  bright,
	input  wire logic [lcpd_pkg::PER_W-1:0]     period,
	output logic [lcpd_pkg::DUTY_W-1:0]         warm_s8,
	output logic [lcpd_pkg::DUTY_W-1:0]         cool_s8,
	output logic [lcpd_pkg::DUTY_W-1:0]         ramp_s8,
	output logic [lcpd_pkg::DUTY_W-1:0]         level_s8,
	output logic                                stat_s8
);
	import lcpd_pkg::*;

	localparam frac_rom_t FRAC_ROM = build_frac();

	localparam int MI_W = KOFF_W;
	localparam logic [MI_W-1:0] MI = MI_W'((64'd1 << KOFF_W) / K_STEP);
	localparam int MR_W = KOFF_W;
	localparam logic [MR_W-1:0] MR = MR_W'((64'd1 << KOFF_W) / RAMP_STEP);
	localparam int PB_W = PER_W + BRIGHT_W;
	localparam int MB_W = PB_W - 9;
	localparam logic [MB_W-1:0] MB = MB_W'((64'd1 << PB_W) / BRIGHT_FULL);
	localparam int PR_W = RAMP_W + PER_W;
	localparam int MP_W = PR_W - 6;
	localparam logic [MP_W-1:0] MP = MP_W'((64'd1 << PR_W) / RAMP_MAX);
	localparam int FW_W = FRAC_W + PER_W;
	localparam int W_W  = FW_W + BRIGHT_W - FRAC_SH;
	localparam int MW_W = W_W - 9;
	localparam logic [MW_W-1:0] MW = MW_W'((64'd1 << W_W) / BRIGHT_FULL);

	// stage 1 decode
	logic              lo, hi, hir;
	logic [KOFF_W-1:0] koff;
	logic [KOFF_W+MI_W-1:0] prodi;
	logic [KOFF_W+MR_W-1:0] prodr;

	assign lo    = kelvin < KELVIN_W'(K_LOW);
	assign hi    = kelvin > KELVIN_W'(K_TOP);
	assign hir   = kelvin > KELVIN_W'(K_HIGH);
	assign koff  = (lo || hi) ? '0 : KOFF_W'(kelvin - KELVIN_W'(K_LOW));
	assign prodi = (KOFF_W+MI_W)'(koff) * (KOFF_W+MI_W)'(MI);
	assign prodr = (KOFF_W+MR_W)'(koff) * (KOFF_W+MR_W)'(MR);

	logic [KOFF_W-1:0]   koff_s2;
	logic [IDX_W-1:0]    idx0_s2, idx_s3;
	logic [RAMP_W-1:0]   ramp0_s2, ramp_s3;
	logic                lo_s2, hi_s2, hir_s2;
	logic [BRIGHT_W-1:0] b_s2, b_s3, b_s4, b_s5;
	logic [PB_W-1:0]     pb_s2, pb_s3;
	logic [DUTY_W-1:0]   bq_s3, lv_s4, lv_s5, lv_s6, lv_s7;
	logic                stat_s3, stat_s4, stat_s5, stat_s6, stat_s7;
	logic [FRAC_W-1:0]   f_s4;
	logic [PR_W-1:0]     pr_s4, pr_s5;
	logic [DUTY_W-1:0]   rq_s5, rd_s6, rd_s7;
	logic [FW_W-1:0]     fw_s5, fc_s5;
	logic [W_W-1:0]      w_s6, c_s6, w_s7, c_s7;
	logic [DUTY_W-1:0]   wq_s7, cq_s7;

	logic [KOFF_W-1:0]      ri, rr;
	logic [RAMP_W-1:0]      ramp_c;
	logic [IDX_W-1:0]       idx_c, rom_addr;
	logic [PB_W+MB_W-1:0]   prodb;
	logic [PB_W-1:0]        rb;
	logic [PR_W+MP_W-1:0]   prodp;
	logic [PR_W-1:0]        rp;
	logic [FW_W+BRIGHT_W-1:0] ww, cw;
	logic [W_W+MW_W-1:0]    prodw, prodc;
	logic [W_W-1:0]         rw, rc;

	assign ri     = koff_s2 - KOFF_W'(idx0_s2) * KOFF_W'(K_STEP);
	assign idx_c  = idx0_s2 + IDX_W'(ri >= KOFF_W'(K_STEP));
	assign rr     = koff_s2 - KOFF_W'(ramp0_s2) * KOFF_W'(RAMP_STEP);
	assign ramp_c = ramp0_s2 + RAMP_W'(rr >= KOFF_W'(RAMP_STEP));
	assign prodb  = (PB_W+MB_W)'(pb_s2) * (PB_W+MB_W)'(MB);
	assign rb     = pb_s3 - PB_W'(bq_s3) * PB_W'(BRIGHT_FULL);
	assign rom_addr = (idx_s3 < IDX_W'(TABLE_DEPTH)) ? idx_s3 : '0;
	assign prodp  = (PR_W+MP_W)'(pr_s4) * (PR_W+MP_W)'(MP);
	assign rp     = pr_s5 - PR_W'(rq_s5) * PR_W'(RAMP_MAX);
	assign ww     = (FW_W+BRIGHT_W)'(fw_s5) * (FW_W+BRIGHT_W)'(b_s5);
	assign cw     = (FW_W+BRIGHT_W)'(fc_s5) * (FW_W+BRIGHT_W)'(b_s5);
	assign prodw  = (W_W+MW_W)'(w_s6) * (W_W+MW_W)'(MW);
	assign prodc  = (W_W+MW_W)'(c_s6) * (W_W+MW_W)'(MW);
	assign rw     = w_s7 - W_W'(wq_s7) * W_W'(BRIGHT_FULL);
	assign rc     = c_s7 - W_W'(cq_s7) * W_W'(BRIGHT_FULL);

	always_ff @(posedge clk) begin
		if (en) begin
			koff_s2  <= koff;
			idx0_s2  <= prodi[KOFF_W +: IDX_W];
			ramp0_s2 <= prodr[KOFF_W +: RAMP_W];
			lo_s2    <= lo;
			hi_s2    <= hi;
			hir_s2   <= hir;
			b_s2     <= bright;
			pb_s2    <= PB_W'(bright) * PB_W'(period);

			idx_s3   <= idx_c;
			stat_s3  <= lo_s2 || hi_s2 || (idx_c >= IDX_W'(TABLE_DEPTH));
			priority if (lo_s2) ramp_s3 <= '0;
			else if (hir_s2)    ramp_s3 <= RAMP_W'(RAMP_MAX);
			else                ramp_s3 <= ramp_c;
			b_s3     <= b_s2;
			bq_s3    <= prodb[PB_W +: DUTY_W];
			pb_s3    <= pb_s2;

			f_s4     <= FRAC_ROM[rom_addr];
			pr_s4    <= PR_W'(ramp_s3) * PR_W'(period);
			lv_s4    <= bq_s3 + DUTY_W'(rb >= PB_W'(BRIGHT_FULL));
			b_s4     <= b_s3;
			stat_s4  <= stat_s3;

			fw_s5    <= FW_W'(f_s4) * FW_W'(period);
			fc_s5    <= FW_W'(FRAC_W'(FRAC_ONE) - f_s4) * FW_W'(period);
			rq_s5    <= prodp[PR_W +: DUTY_W];
			pr_s5    <= pr_s4;
			lv_s5    <= lv_s4;
			b_s5     <= b_s4;
			stat_s5  <= stat_s4;

			w_s6     <= ww[FRAC_SH +: W_W];
			c_s6     <= cw[FRAC_SH +: W_W];
			rd_s6    <= rq_s5 + DUTY_W'(rp >= PR_W'(RAMP_MAX));
			lv_s6    <= lv_s5;
			stat_s6  <= stat_s5;

			wq_s7    <= prodw[W_W +: DUTY_W];
			cq_s7    <= prodc[W_W +: DUTY_W];
			w_s7     <= w_s6;
			c_s7     <= c_s6;
			rd_s7    <= rd_s6;
			lv_s7    <= lv_s6;
			stat_s7  <= stat_s6;

			warm_s8  <= wq_s7 + DUTY_W'(rw >= W_W'(BRIGHT_FULL));
			cool_s8  <= cq_s7 + DUTY_W'(rc >= W_W'(BRIGHT_FULL));
			ramp_s8  <= rd_s7;
			level_s8 <= lv_s7;
			stat_s8  <= stat_s7;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/led_colour_to_pwm_duty.sv
// LED colour to PWM duty converter, top level.
// Depends on lcpd_pkg, lcpd_if, lcpd_cfg, lcpd_rgb_lane, lcpd_white.
//
// Usage:
//   req  : one transaction per colour request (RGB or white temperature).
//   duty : one transaction per request: five duty counts and a status bit.
//   cfg  : register writes (index 0 period, 1 white drive mode, 2 polarity
//          mask); always ready, write only while no request is in flight.
// Throughput: one request per cycle when not stalled; the path is a 9-stage pipeline
//   set by the chained multiply / reciprocal-correct steps of the warm/cool split.
// The warm fraction table is a registered ROM read in stage 4.
// Stall: while duty.valid is high and duty.ready low, the whole pipeline
//   holds and req.ready drops; nothing is lost or repeated.
// Reset: clears all stage valid bits and loads period 1000, warm/cool
//   drive and all channels active high.
`default_nettype none

module led_colour_to_pwm_duty (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lcpd_req_if.sink   req,
	lcpd_duty_if.source duty,
	lcpd_cfg_if.sink   cfg
);
	import lcpd_pkg::*;

	localparam int NSTAGE = 9;

	cfg_regs_t regs;
	logic      en;
	logic [NSTAGE-1:0] vld_q;

	lcpd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign en        = !vld_q[NSTAGE-1] || duty.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTAGE-2:0], req.valid};
		end
	end

	// stage 1 input register
	logic                kind_s1, mode_s1;
	logic [RGB_W-1:0]    rgb_s1;
	logic [KELVIN_W-1:0] kel_s1;
	logic [BRIGHT_W-1:0] b_s1;
	logic [1:0]          ctl_q [2:8];

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= req.kind;
			mode_s1 <= regs.white_mode;
			rgb_s1  <= req.colour_rgb;
			kel_s1  <= req.colour_temp_kelvin;
			b_s1    <= (req.brightness > BRIGHT_W'(BRIGHT_FULL)) ?
				BRIGHT_W'(BRIGHT_FULL) : req.brightness;
			ctl_q[2] <= {kind_s1, mode_s1};
			for (int i = 3; i <= 8; i++) ctl_q[i] <= ctl_q[i-1];
		end
	end

	logic [DUTY_W-1:0] red_s8, green_s8, blue_s8;
	logic [DUTY_W-1:0] warm_s8, cool_s8, ramp_s8, level_s8;
	logic              stat_s8;

	lcpd_rgb_lane u_red (
		.clk (clk), .en (en), .level (rgb_s1[23:16]), .bright (b_s1),
		.period (regs.period), .duty_s8 (red_s8)
	);
	lcpd_rgb_lane u_green (
		.clk (clk), .en (en), .level (rgb_s1[15:8]), .bright (b_s1),
		.period (regs.period), .duty_s8 (green_s8)
	);
	lcpd_rgb_lane u_blue (
		.clk (clk), .en (en), .level (rgb_s1[7:0]), .bright (b_s1),
		.period (regs.period), .duty_s8 (blue_s8)
	);

	lcpd_white u_white (
		.clk      (clk),
		.en       (en),
		.kelvin   (kel_s1),
		.bright   (b_s1),
		.period   (regs.period),
		.warm_s8  (warm_s8),
		.cool_s8  (cool_s8),
		.ramp_s8  (ramp_s8),
		.level_s8 (level_s8),
		.stat_s8  (stat_s8)
	);

	function automatic logic [DUTY_W-1:0] pol(input logic [DUTY_W-1:0] d,
		input logic hi, input logic [PER_W-1:0] per);
		return hi ? d : DUTY_W'(per - d);
	endfunction

	// stage 9: channel select, polarity, output register
	logic [DUTY_W-1:0] r_s9, g_s9, bl_s9, third_s9, fourth_s9;
	logic              stat_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s9      <= '0;
			g_s9      <= '0;
			bl_s9     <= '0;
			third_s9  <= '0;
			fourth_s9 <= '0;
			stat_s9   <= 1'b0;
			priority if (!ctl_q[8][1]) begin
				r_s9  <= pol(red_s8, regs.active_high[CH_RED], regs.period);
				g_s9  <= pol(green_s8, regs.active_high[CH_GREEN], regs.period);
				bl_s9 <= pol(blue_s8, regs.active_high[CH_BLUE], regs.period);
			end else if (ctl_q[8][0]) begin
				third_s9  <= ramp_s8;
				fourth_s9 <= pol(level_s8, regs.active_high[CH_BRIGHT], regs.period);
			end else if (stat_s8) begin
				stat_s9 <= 1'b1;
			end else begin
				third_s9  <= pol(warm_s8, regs.active_high[CH_WARM], regs.period);
				fourth_s9 <= pol(cool_s8, regs.active_high[CH_COOL], regs.period);
			end
		end
	end

	assign duty.valid             = vld_q[NSTAGE-1];
	assign duty.duty_red          = r_s9;
	assign duty.duty_green        = g_s9;
	assign duty.duty_blue         = bl_s9;
	assign duty.duty_third_white  = third_s9;
	assign duty.duty_fourth_white = fourth_s9;
	assign duty.status            = stat_s9;

`ifndef SYNTHESIS
	a_status_blank: assert property (@(posedge clk) disable iff (!arst_n)
		duty.valid && duty.status |-> duty.duty_red == '0 && duty.duty_green == '0 &&
		duty.duty_blue == '0 && duty.duty_third_white == '0 &&
		duty.duty_fourth_white == '0)
		else $error("status set with nonzero duty");
	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] && en |=> vld_q[1])
		else $error("valid bit lost between stages");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire
